// File: rtl/core/cawf_pkg.sv
`default_nettype none
package cawf_pkg;

  // Default build values
  localparam int MAX_WORD_DEF    = 32;
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  // Fixed register and field widths
  localparam int WORD_LEN_BITS = 6;
  localparam int CHAR_REGS     = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int TAG_BITS      = 16;

  // Characters of interest
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_STAR       = 8'h2A;
  localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WORD_LENGTH  = 3'd0,
    CFG_WORD_CHARS_0 = 3'd1,
    CFG_WORD_CHARS_1 = 3'd2,
    CFG_WORD_CHARS_2 = 3'd3,
    CFG_WORD_CHARS_3 = 3'd4,
    CFG_DOCUMENT_TAG = 3'd5
  } cawf_cfg_idx_t;

  // Byte class flags worked out by the front
  typedef struct packed {
    logic is_letter;
    logic is_word;
    logic is_slash;
    logic is_star;
    logic is_dquote;
    logic is_squote;
    logic is_backslash;
    logic is_newline;
  } cawf_class_t;

  // One queued item
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        end_of_text;
    cawf_class_t cls;
  } cawf_item_t;

  // Scanner modes
  typedef enum logic [7:0] {
    MODE_NORMAL     = 8'b0000_0001,
    MODE_SLASH      = 8'b0000_0010,
    MODE_LINE       = 8'b0000_0100,
    MODE_BLOCK      = 8'b0000_1000,
    MODE_BLOCK_STAR = 8'b0001_0000,
    MODE_STRING     = 8'b0010_0000,
    MODE_STRING_ESC = 8'b0100_0000,
    MODE_IDENT      = 8'b1000_0000
  } cawf_mode_t;

endpackage
`default_nettype wire

// File: rtl/core/cawf_in_if.sv
`default_nettype none
interface cawf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cawf_out_if.sv
`default_nettype none
interface cawf_out_if #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   is_match;
  logic                   document_done;
  logic [LINE_BITS-1:0]   match_line;
  logic [COLUMN_BITS-1:0] first_column;
  logic [COLUMN_BITS-1:0] past_column;
  logic [15:0]            source_tag;

  modport source (
    output valid, output is_match, output document_done, output match_line,
    output first_column, output past_column, output source_tag, input ready
  );
  modport sink (
    input valid, input is_match, input document_done, input match_line,
    input first_column, input past_column, input source_tag, output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/cawf_front.sv
`default_nettype none
module cawf_front import cawf_pkg::*; (
  cawf_in_if.sink    in_chan,
  input  wire logic  q_full,
  output cawf_item_t q_item,
  output logic       q_push
);

  logic [7:0] b;

  assign b = in_chan.text_byte;

  // Take an item whenever the queue has room
  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Classify the byte
  always_comb begin
    q_item.text_byte        = b;
    q_item.end_of_text      = in_chan.end_of_text;
    q_item.cls.is_letter    = b inside {[8'h61:8'h7A], [8'h41:8'h5A], CHAR_UNDERSCORE};
    q_item.cls.is_word      = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                        CHAR_UNDERSCORE};
    q_item.cls.is_slash     = (b == CHAR_SLASH);
    q_item.cls.is_star      = (b == CHAR_STAR);
    q_item.cls.is_dquote    = (b == CHAR_DQUOTE);
    q_item.cls.is_squote    = (b == CHAR_SQUOTE);
    q_item.cls.is_backslash = (b == CHAR_BACKSLASH);
    q_item.cls.is_newline   = (b == CHAR_NEWLINE);
  end

endmodule
`default_nettype wire

// File: rtl/core/cawf_queue.sv
`default_nettype none
module cawf_queue import cawf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cawf_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output cawf_item_t      pop_item,
  output logic            not_empty
);

  localparam int Depth = QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  cawf_item_t      slots_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = slots_r[rd_r];

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cawf_back.sv
`default_nettype none
module cawf_back import cawf_pkg::*; #(
  parameter int MAX_WORD    = MAX_WORD_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     q_valid,
  input  wire cawf_item_t               q_item,
  output logic                          q_pop,
  cawf_out_if.source                    out_chan
);

  localparam logic [WORD_LEN_BITS:0]   MaxWordW = (WORD_LEN_BITS+1)'(MAX_WORD);
  localparam logic [WORD_LEN_BITS-1:0] LenMax   = '1;

  // Configuration registers
  logic [WORD_LEN_BITS-1:0]                word_len_r;
  logic [CHAR_REGS-1:0][CFG_DATA_BITS-1:0] chars_r;
  logic [TAG_BITS-1:0]                     tag_r;
  logic [CHAR_REGS*8-1:0][7:0]             word_bytes;

  // Scanner state
  cawf_mode_t               mode_r, mode_nxt;
  logic                     quote_r, quote_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [COLUMN_BITS-1:0]   col_r, col_nxt;
  logic [COLUMN_BITS-1:0]   start_r, start_nxt;
  logic [WORD_LEN_BITS-1:0] len_r, len_nxt;
  logic                     eq_r, eq_nxt;

  // Result register
  logic                   out_valid_r;
  logic                   res_match_r;
  logic                   res_done_r;
  logic [LINE_BITS-1:0]   res_line_r;
  logic [COLUMN_BITS-1:0] res_first_r;
  logic [COLUMN_BITS-1:0] res_past_r;
  logic [TAG_BITS-1:0]    res_tag_r;

  cawf_class_t              c;
  logic                     last;
  logic                     check_end;
  logic                     take_normal;
  logic                     wl_ok;
  logic                     matched;
  logic                     emit;
  logic [COLUMN_BITS-1:0]   hit_start;
  logic [WORD_LEN_BITS-1:0] hit_len;
  logic [COLUMN_BITS:0]     past_sum;
  logic [COLUMN_BITS-1:0]   past_cap;

  assign word_bytes = chars_r;
  assign c          = q_item.cls;
  assign last       = q_item.end_of_text;

  // Does the identifier still equal the word after one more byte
  function automatic logic extend_equal(
    input logic                       eq,
    input logic [WORD_LEN_BITS-1:0]   len,
    input logic [7:0]                 b,
    input logic [WORD_LEN_BITS-1:0]   wl,
    input logic [CHAR_REGS*8-1:0][7:0] wb
  );
    extend_equal = eq && (len < wl) && ({1'b0, len} < MaxWordW) && (b == wb[len[4:0]]);
  endfunction

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r <= '0;
      chars_r    <= '0;
      tag_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORD_LENGTH:  word_len_r <= cfg_data[WORD_LEN_BITS-1:0];
        CFG_WORD_CHARS_0: chars_r[0] <= cfg_data;
        CFG_WORD_CHARS_1: chars_r[1] <= cfg_data;
        CFG_WORD_CHARS_2: chars_r[2] <= cfg_data;
        CFG_WORD_CHARS_3: chars_r[3] <= cfg_data;
        CFG_DOCUMENT_TAG: tag_r      <= cfg_data[TAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Take the next item when the result register is free or draining
  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  assign wl_ok = (word_len_r != '0) && ({1'b0, word_len_r} <= MaxWordW);

  // Scanner next state
  always_comb begin
    mode_nxt    = mode_r;
    quote_nxt   = quote_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    eq_nxt      = eq_r;
    check_end   = 1'b0;
    take_normal = 1'b0;

    case (mode_r)
      MODE_IDENT: begin
        if (c.is_word) begin
          len_nxt = (len_r == LenMax) ? len_r : len_r + WORD_LEN_BITS'(1);
          eq_nxt  = extend_equal(eq_r, len_r, q_item.text_byte, word_len_r, word_bytes);
        end else begin
          check_end   = 1'b1;
          take_normal = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c.is_slash) begin
          mode_nxt = MODE_LINE;
        end else if (c.is_star) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          take_normal = 1'b1;
        end
      end
      MODE_LINE: begin
        if (c.is_newline) mode_nxt = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (c.is_star) mode_nxt = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (c.is_slash) begin
          mode_nxt = MODE_NORMAL;
        end else if (!c.is_star) begin
          mode_nxt = MODE_BLOCK;
        end
      end
      MODE_STRING: begin
        if (c.is_backslash) begin
          mode_nxt = MODE_STRING_ESC;
        end else if (quote_r ? c.is_squote : c.is_dquote) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_STRING_ESC: mode_nxt = MODE_STRING;
      default: take_normal = 1'b1;
    endcase

    // Byte seen as plain text
    if (take_normal) begin
      if (c.is_slash) begin
        mode_nxt = MODE_SLASH;
      end else if (c.is_dquote || c.is_squote) begin
        mode_nxt  = MODE_STRING;
        quote_nxt = c.is_squote;
      end else if (c.is_letter) begin
        mode_nxt  = MODE_IDENT;
        start_nxt = col_r;
        len_nxt   = WORD_LEN_BITS'(1);
        eq_nxt    = extend_equal(1'b1, '0, q_item.text_byte, word_len_r, word_bytes);
      end else begin
        mode_nxt = MODE_NORMAL;
      end
    end

    // An identifier still open on the final byte ends there
    if (last && (mode_nxt == MODE_IDENT)) check_end = 1'b1;

    matched = check_end && eq_nxt && wl_ok && (len_nxt == word_len_r);
    emit    = matched || last;

    // Identifier span as seen before any restart
    hit_start = start_nxt;
    hit_len   = len_nxt;

    // Line and column counting
    if (c.is_newline) begin
      line_nxt = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);
      col_nxt  = '0;
    end else begin
      line_nxt = line_r;
      col_nxt  = (col_r == '1) ? col_r : col_r + COLUMN_BITS'(1);
    end

    // Restart for the next document
    if (last) begin
      mode_nxt  = MODE_NORMAL;
      quote_nxt = 1'b0;
      line_nxt  = '0;
      col_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      eq_nxt    = 1'b1;
    end
  end

  // End column, capped
  assign past_sum = {1'b0, hit_start} + (COLUMN_BITS+1)'(hit_len);
  assign past_cap = past_sum[COLUMN_BITS] ? '1 : past_sum[COLUMN_BITS-1:0];

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      quote_r <= 1'b0;
      line_r  <= '0;
      col_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      eq_r    <= 1'b1;
    end else if (q_pop) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      eq_r    <= eq_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res_match_r <= matched;
      res_done_r  <= last;
      res_line_r  <= matched ? line_r : '0;
      res_first_r <= matched ? hit_start : '0;
      res_past_r  <= matched ? past_cap : '0;
      res_tag_r   <= tag_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.is_match      = res_match_r;
  assign out_chan.document_done = res_done_r;
  assign out_chan.match_line    = res_line_r;
  assign out_chan.first_column  = res_first_r;
  assign out_chan.past_column   = res_past_r;
  assign out_chan.source_tag    = res_tag_r;

endmodule
`default_nettype wire

// File: rtl/core/comment_aware_whole_word_finder_unit.sv
// Whole-word identifier finder that skips comments and quoted strings.
// A result is registered by the scanner after its item is accepted into the
// front queue and then taken from it; the scanner takes an item only when
// its result register is free or being drained.
// Throughput: one item per cycle while results are taken; a held result stalls it.
// Reset (rst_n low, synchronous) clears the scanner, queue, result valid
// and all configuration registers.
`default_nettype none
module comment_aware_whole_word_finder_unit import cawf_pkg::*; #(
  parameter int MAX_WORD    = MAX_WORD_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  cawf_in_if.sink                       in_chan,
  cawf_out_if.source                    out_chan,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cawf_item_t push_item;
  cawf_item_t pop_item;
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;

  // Front: accept and classify
  cawf_front u_front (
    .in_chan (in_chan),
    .q_full  (full),
    .q_item  (push_item),
    .q_push  (push)
  );

  // Queue between front and scanner
  cawf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  // Back: scanner and result register
  cawf_back #(
    .MAX_WORD    (MAX_WORD),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (not_empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
  import cawf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 4;
  localparam int MAX_WORD    = MAX_WORD_DEF;
  localparam int LINE_BITS   = LINE_BITS_DEF;
  localparam int COLUMN_BITS = COLUMN_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 18;
  localparam int SETTLE_CYC  = 4;
  localparam int TAIL_CYC    = 8;
  localparam int STALL_CYC   = 90;

  // random phases: word length per phase, special phases by index
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASE_LEN [PHASES] = '{1, 32, 0, 63, 5, 3, 8, 2, 12, 4};
  localparam int HOLD_PHASE  = 4;
  localparam int CALM_PHASE  = 6;
  localparam int PAUSE_PHASE = 7;

  // one result item as the block reports it
  typedef struct packed {
    logic                   is_match;
    logic                   document_done;
    logic [LINE_BITS-1:0]   match_line;
    logic [COLUMN_BITS-1:0] first_column;
    logic [COLUMN_BITS-1:0] past_column;
    logic [TAG_BITS-1:0]    source_tag;
  } find_result_t;

  // directed stimulus row; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0]   text_byte;
    logic         end_of_text;
    logic         typed;
    find_result_t due;
  } text_row_t;

  localparam find_result_t NO_HIT     = '0;
  localparam find_result_t RESET_DONE = {1'b0, 1'b1, 20'd0, 16'd0, 16'd0, 16'h0000};
  localparam find_result_t FIRST_HIT  = {1'b1, 1'b0, 20'd0, 16'd0, 16'd2, 16'hFFFF};
  localparam find_result_t TAG_DONE   = {1'b0, 1'b1, 20'd0, 16'd0, 16'd0, 16'hFFFF};

  // first rows run on reset settings, the rest with the word "ab"
  localparam int RESET_ROWS = 3;
  localparam int DIR_N      = 30;
  localparam text_row_t DIR_ROWS [DIR_N] = '{
    {"a",             1'b1, 1'b1, RESET_DONE},
    {8'h00,           1'b1, 1'b1, RESET_DONE},
    {8'hFF,           1'b1, 1'b1, RESET_DONE},
    {"a",             1'b0, 1'b0, NO_HIT},
    {"b",             1'b0, 1'b0, NO_HIT},
    {8'h80,           1'b0, 1'b1, FIRST_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {CHAR_STAR,       1'b0, 1'b0, NO_HIT},
    {"b",             1'b0, 1'b0, NO_HIT},
    {CHAR_STAR,       1'b0, 1'b0, NO_HIT},
    {CHAR_STAR,       1'b0, 1'b0, NO_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {CHAR_DQUOTE,     1'b0, 1'b0, NO_HIT},
    {CHAR_BACKSLASH,  1'b0, 1'b0, NO_HIT},
    {CHAR_NEWLINE,    1'b0, 1'b0, NO_HIT},
    {CHAR_DQUOTE,     1'b0, 1'b0, NO_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {CHAR_NEWLINE,    1'b0, 1'b0, NO_HIT},
    {CHAR_SQUOTE,     1'b0, 1'b0, NO_HIT},
    {CHAR_DQUOTE,     1'b0, 1'b0, NO_HIT},
    {CHAR_SQUOTE,     1'b0, 1'b0, NO_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {"a",             1'b0, 1'b0, NO_HIT},
    {"b",             1'b1, 1'b0, NO_HIT},
    {"a",             1'b0, 1'b0, NO_HIT},
    {"b",             1'b0, 1'b0, NO_HIT},
    {"9",             1'b0, 1'b0, NO_HIT},
    {CHAR_SLASH,      1'b0, 1'b0, NO_HIT},
    {CHAR_STAR,       1'b1, 1'b1, TAG_DONE}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  cawf_in_if in_if ();
  cawf_out_if #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) out_if ();

  comment_aware_whole_word_finder_unit #(
    .MAX_WORD    (MAX_WORD),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // results still owed by the block, oldest first
  find_result_t due_hits [$];
  int           fail_count    = 0;
  bit           calm          = 1'b0;
  int           stall_request = 0;
  logic [7:0]   word_q [$];
  logic [7:0]   doc_q [$];

  // shadow settings
  logic [WORD_LEN_BITS-1:0] word_len_cfg = '0;
  logic [63:0]              word_chars_cfg [CHAR_REGS] = '{default: '0};
  logic [TAG_BITS-1:0]      tag_cfg = '0;

  // shadow scanner state
  cawf_mode_t             mode        = MODE_NORMAL;
  bit                     quote_sq    = 1'b0;
  logic [LINE_BITS-1:0]   cur_line    = '0;
  logic [COLUMN_BITS-1:0] cur_col     = '0;
  logic [COLUMN_BITS-1:0] id_start    = '0;
  logic [5:0]             id_len      = '0;
  bit                     id_eq       = 1'b1;

  task automatic log_fail(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CHAR_UNDERSCORE;
  endfunction

  function automatic bit is_wordc(logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  // one more identifier byte: still equal only while it lines up with the word
  function automatic void grow_ident(logic [7:0] c);
    logic [7:0] want;
    want = word_chars_cfg[id_len[4:3]][{id_len[2:0], 3'b000} +: 8];
    if (id_len >= word_len_cfg || id_len >= MAX_WORD || c != want) id_eq = 1'b0;
    if (id_len != 6'd63) id_len++;
  endfunction

  function automatic void take_normal(logic [7:0] c);
    if (c == CHAR_SLASH) begin
      mode = MODE_SLASH;
    end else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
      mode = MODE_STRING;
      quote_sq = (c == CHAR_SQUOTE);
    end else if (is_alpha(c)) begin
      mode = MODE_IDENT;
      id_start = cur_col;
      id_len = '0;
      id_eq = 1'b1;
      grow_ident(c);
    end else begin
      mode = MODE_NORMAL;
    end
  endfunction

  function automatic void restart_doc();
    mode = MODE_NORMAL;
    quote_sq = 1'b0;
    cur_line = '0;
    cur_col = '0;
    id_start = '0;
    id_len = '0;
    id_eq = 1'b1;
  endfunction

  // advance the shadow scanner by one byte; returns 1 when a result is owed
  function automatic bit scan_byte(input logic [7:0] c, input bit last,
                                   output find_result_t res);
    bit          ends;
    bit          hit;
    logic [16:0] past;
    ends = 1'b0;
    hit = 1'b0;
    res = '0;
    case (mode)
      MODE_IDENT: begin
        if (is_wordc(c)) grow_ident(c);
        else ends = 1'b1;
      end
      MODE_SLASH: begin
        if (c == CHAR_SLASH) mode = MODE_LINE;
        else if (c == CHAR_STAR) mode = MODE_BLOCK;
        else take_normal(c);
      end
      MODE_LINE: begin
        if (c == CHAR_NEWLINE) mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (c == CHAR_STAR) mode = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (c == CHAR_SLASH) mode = MODE_NORMAL;
        else if (c != CHAR_STAR) mode = MODE_BLOCK;
      end
      MODE_STRING: begin
        if (c == CHAR_BACKSLASH) mode = MODE_STRING_ESC;
        else if (c == (quote_sq ? CHAR_SQUOTE : CHAR_DQUOTE)) mode = MODE_NORMAL;
      end
      MODE_STRING_ESC: begin
        mode = MODE_STRING;
      end
      default: begin
        take_normal(c);
      end
    endcase

    // an identifier open on the final byte ends there
    if (last && mode == MODE_IDENT) ends = 1'b1;

    if (ends) begin
      if (id_eq && word_len_cfg != 0 && word_len_cfg <= MAX_WORD && id_len == word_len_cfg)
      begin
        hit = 1'b1;
        past = {1'b0, id_start} + id_len;
        res.is_match = 1'b1;
        res.match_line = cur_line;
        res.first_column = id_start;
        res.past_column = past[16] ? '1 : past[15:0];
      end
      if (mode == MODE_IDENT && !is_wordc(c)) begin
        mode = MODE_NORMAL;
        take_normal(c);
      end
    end

    // line and column, both saturating
    if (c == CHAR_NEWLINE) begin
      if (cur_line != '1) cur_line++;
      cur_col = '0;
    end else if (cur_col != '1) begin
      cur_col++;
    end

    if (last) restart_doc();
    if (!hit && !last) return 1'b0;
    res.document_done = last;
    res.source_tag = tag_cfg;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CHAR_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_word_byte();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    return rand_letter();
  endfunction

  // bytes that stress comment and string handling
  function automatic logic [7:0] pick_junk();
    case ($urandom_range(0, 9))
      0: return CHAR_STAR;
      1: return CHAR_SLASH;
      2: return CHAR_DQUOTE;
      3: return CHAR_SQUOTE;
      4: return CHAR_BACKSLASH;
      5: return " ";
      6: return CHAR_NEWLINE;
      7: return (word_q.size() != 0) ? word_q[$urandom_range(0, word_q.size() - 1)]
                                     : rand_letter();
      default: return rand_word_byte();
    endcase
  endfunction

  task automatic write_reg(cawf_cfg_idx_t idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_WORD_LENGTH:  word_len_cfg = val[WORD_LEN_BITS-1:0];
      CFG_WORD_CHARS_0: word_chars_cfg[0] = val;
      CFG_WORD_CHARS_1: word_chars_cfg[1] = val;
      CFG_WORD_CHARS_2: word_chars_cfg[2] = val;
      CFG_WORD_CHARS_3: word_chars_cfg[3] = val;
      CFG_DOCUMENT_TAG: tag_cfg = val[TAG_BITS-1:0];
      default: ;
    endcase
  endtask

  // program a search word; unused character bytes and upper bits get junk
  task automatic load_word(int len, logic [15:0] tag, string fixed);
    logic [63:0] regs [CHAR_REGS];
    logic [63:0] val;
    logic [7:0]  c;
    int          i;
    for (i = 0; i < CHAR_REGS; i++) regs[i] = {$urandom, $urandom};
    word_q.delete();
    for (i = 0; i < len && i < MAX_WORD; i++) begin
      if (i < fixed.len()) c = fixed[i];
      else if (i == 0) c = rand_letter();
      else c = rand_word_byte();
      regs[i / 8][(i % 8) * 8 +: 8] = c;
      word_q.push_back(c);
    end
    // now and then a word with one byte replaced by a random byte
    if (fixed.len() == 0 && word_q.size() > 1 && $urandom_range(0, 7) == 0) begin
      i = $urandom_range(1, word_q.size() - 1);
      c = 8'($urandom_range(0, 255));
      regs[i / 8][(i % 8) * 8 +: 8] = c;
      word_q[i] = c;
    end
    val = {$urandom, $urandom};
    val[WORD_LEN_BITS-1:0] = len[WORD_LEN_BITS-1:0];
    write_reg(CFG_WORD_LENGTH, val);
    for (i = 0; i < CHAR_REGS; i++) write_reg(cawf_cfg_idx_t'(CFG_WORD_CHARS_0 + i), regs[i]);
    val = {$urandom, $urandom};
    val[TAG_BITS-1:0] = tag;
    write_reg(CFG_DOCUMENT_TAG, val);
    cfg_we <= 1'b0;
  endtask

  // offer one item, wait for the handshake, then update the prediction
  task automatic send_byte(logic [7:0] c, bit last, bit typed, find_result_t typed_due);
    find_result_t res;
    bit           owed;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= c;
    in_if.end_of_text <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    owed = scan_byte(c, last, res);
    if (typed) begin
      res = typed_due;
      owed = 1'b1;
    end
    if (owed) due_hits.push_back(res);
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1, 1'b0, NO_HIT);
  endtask

  // wait out every owed result, then hold the input idle while the block settles
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (due_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // one lexical token of random content, mostly well formed
  task automatic add_token();
    int         pick;
    int         k;
    int         j;
    logic [7:0] q;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 40 && word_q.size() != 0) begin
      if (pick < 28) begin
        foreach (word_q[j]) doc_q.push_back(word_q[j]);
      end else if (pick < 34) begin
        // proper prefix, or the word with one more byte
        k = $urandom_range(1, word_q.size());
        for (j = 0; j < k; j++) doc_q.push_back(word_q[j]);
        if (k == word_q.size()) doc_q.push_back(rand_word_byte());
      end else begin
        doc_q.push_back(rand_letter());
        foreach (word_q[j]) doc_q.push_back(word_q[j]);
      end
    end else if (pick < 52) begin
      k = $urandom_range(1, 6);
      doc_q.push_back(rand_letter());
      for (j = 1; j < k; j++) doc_q.push_back(rand_word_byte());
    end else if (pick < 64) begin
      case ($urandom_range(0, 5))
        0: doc_q.push_back(" ");
        1: doc_q.push_back(CHAR_NEWLINE);
        2: doc_q.push_back(";");
        3: doc_q.push_back("(");
        4: doc_q.push_back(8'h09);
        default: doc_q.push_back("+");
      endcase
    end else if (pick < 71) begin
      // line comment
      doc_q.push_back(CHAR_SLASH);
      doc_q.push_back(CHAR_SLASH);
      repeat ($urandom_range(0, 8)) begin
        c = pick_junk();
        doc_q.push_back(c == CHAR_NEWLINE ? CHAR_STAR : c);
      end
      doc_q.push_back(CHAR_NEWLINE);
    end else if (pick < 78) begin
      // block comment, sometimes left open
      doc_q.push_back(CHAR_SLASH);
      doc_q.push_back(CHAR_STAR);
      repeat ($urandom_range(0, 8)) doc_q.push_back(pick_junk());
      if ($urandom_range(0, 9) != 0) begin
        repeat ($urandom_range(1, 2)) doc_q.push_back(CHAR_STAR);
        doc_q.push_back(CHAR_SLASH);
      end
    end else if (pick < 87) begin
      // quoted string with escapes, sometimes left open
      q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
      doc_q.push_back(q);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          doc_q.push_back(CHAR_BACKSLASH);
          doc_q.push_back($urandom_range(0, 1) ? pick_junk() : 8'($urandom_range(0, 255)));
        end else begin
          c = pick_junk();
          while (c == q || c == CHAR_BACKSLASH) c = pick_junk();
          doc_q.push_back(c);
        end
      end
      if ($urandom_range(0, 9) != 0) doc_q.push_back(q);
    end else if (pick < 94) begin
      // slash that opens no comment
      doc_q.push_back(CHAR_SLASH);
      doc_q.push_back($urandom_range(0, 1) ? rand_letter() : "=");
    end else begin
      repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 8) doc_q.push_back($urandom_range(0, 3) == 0 ? CHAR_NEWLINE : " ");
  endtask

  task automatic build_doc();
    doc_q.delete();
    repeat ($urandom_range(1, 10)) add_token();
  endtask

  // receiver: random backpressure, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin : check_results
    find_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_hits.size() == 0) begin
        log_fail("result item with none expected");
      end else begin
        want = due_hits.pop_front();
        if (out_if.is_match !== want.is_match)
          log_fail($sformatf("is_match %0d, want %0d", out_if.is_match, want.is_match));
        if (out_if.document_done !== want.document_done)
          log_fail($sformatf("document_done %0d, want %0d", out_if.document_done,
                             want.document_done));
        if (out_if.match_line !== want.match_line)
          log_fail($sformatf("match_line %0d, want %0d", out_if.match_line, want.match_line));
        if (out_if.first_column !== want.first_column)
          log_fail($sformatf("first_column %0d, want %0d", out_if.first_column,
                             want.first_column));
        if (out_if.past_column !== want.past_column)
          log_fail($sformatf("past_column %0d, want %0d", out_if.past_column,
                             want.past_column));
        if (out_if.source_tag !== want.source_tag)
          log_fail($sformatf("source_tag %0h, want %0h", out_if.source_tag, want.source_tag));
      end
    end
  end

  // hang guard
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    int p;
    int sent;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.text_byte   <= '0;
    in_if.end_of_text <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_WORD_LENGTH;
    cfg_data          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (i = 0; i < DIR_N; i++) begin
      if (i == RESET_ROWS) begin
        drain_results();
        load_word(2, 16'hFFFF, "ab");
      end
      send_byte(DIR_ROWS[i].text_byte, DIR_ROWS[i].end_of_text, DIR_ROWS[i].typed,
                DIR_ROWS[i].due);
    end

    // random documents, one word setting per phase
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      load_word(PHASE_LEN[p], (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0000 : 16'($urandom), "");
      calm = (p == CALM_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_doc();
        if (p == HOLD_PHASE && sent == 0) stall_request = STALL_CYC;
        send_doc();
        sent += doc_q.size();
        if (p == PAUSE_PHASE) begin
          in_if.valid <= 1'b0;
          while (due_hits.size() != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
